// ----- hdl/next_prime_search_assert.svh -----
// Assertion macros for the next prime search block.
`ifndef NEXT_PRIME_SEARCH_ASSERT_SVH
`define NEXT_PRIME_SEARCH_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define NPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("next_prime_search: same-cycle check failed");
// Next-cycle implication.
`define NPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next_prime_search: next-cycle check failed");
`else
`define NPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/nps_pkg.sv -----
// Shared types and constants of the next prime search block.
`default_nettype none
package nps_pkg;
	localparam int FIRST_PRIME = 2;
	localparam int FIRST_DIVISOR = 3;
	localparam int FIRST_SQUARE = FIRST_DIVISOR * FIRST_DIVISOR;
	localparam int ODD_STEP = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TEST,
		ST_WAIT
	} state_t;

	// Status of the shared remainder unit.
	typedef struct packed {
		logic done;
		logic zero;
	} rem_status_t;

	// Result event from the sequencer.
	typedef struct packed {
		logic valid;
		logic overflow;
	} emit_t;
endpackage
`default_nettype wire

// ----- hdl/next_prime_search.sv -----
// Top level of the next prime search block.
//
// Channel   Direction  Handshake            Payload
// input     in         start, busy          start_value
// result    out        done (one cycle)     prime_value, overflow
//
// Each divisor tried runs on the bit-serial remainder unit that is shared by
// all trials; the candidate found prime ends the search with the square-root
// bound check, and done follows in the cycle after the last check. Starts of
// two or less raise done in the cycle after acceptance. An item is accepted
// when start is high and busy is low; busy stays high until the result is
// out. done is high for one cycle and cannot be held off. Reset (arst_n low)
// returns the block to idle at once.
`default_nettype none
`include "next_prime_search_assert.svh"
module next_prime_search #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	output logic                    busy,
	input  wire  [VALUE_WIDTH-1:0]  start_value,
	output logic                    done,
	output logic [VALUE_WIDTH-1:0]  prime_value,
	output logic                    overflow
);
	import nps_pkg::*;

	localparam int DIV_W = VALUE_WIDTH / 2 + 2;

	emit_t                  emit;
	logic [VALUE_WIDTH-1:0] emit_value;
	logic                   rem_launch;
	logic [VALUE_WIDTH-1:0] rem_dividend;
	logic [DIV_W-1:0]       rem_divisor;
	rem_status_t            rem_status;

	logic                   done_q;
	logic [VALUE_WIDTH-1:0] prime_q;
	logic                   ovf_q;

	nps_seq #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.start_value(start_value),
		.busy(busy),
		.emit(emit),
		.emit_value(emit_value),
		.rem_launch(rem_launch),
		.rem_dividend(rem_dividend),
		.rem_divisor(rem_divisor),
		.rem_status(rem_status)
	);

	nps_rem_unit #(
		.DIVIDEND_W(VALUE_WIDTH),
		.DIVISOR_W(DIV_W)
	) u_rem (
		.clk(clk),
		.arst_n(arst_n),
		.launch(rem_launch),
		.dividend(rem_dividend),
		.divisor(rem_divisor),
		.status(rem_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			prime_q <= emit_value;
			ovf_q <= emit.overflow;
		end
	end

	assign done = done_q;
	assign prime_value = prime_q;
	assign overflow = ovf_q;

	`NPS_ASSERT_IMP(a_ovf_zero, clk, arst_n, done && overflow, prime_value == '0)
	`NPS_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`NPS_ASSERT_NEXT(a_accept_moves, clk, arst_n, start && !busy, busy || done)
	`NPS_ASSERT_IMP(a_prime_odd, clk, arst_n, done && !overflow,
		prime_value[0] || prime_value == VALUE_WIDTH'(FIRST_PRIME))
endmodule
`default_nettype wire

// ----- hdl/nps_rem_unit.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module nps_rem_unit #(
	parameter int DIVIDEND_W = 32,
	parameter int DIVISOR_W = 18
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     launch,
	input  wire  [DIVIDEND_W-1:0]   dividend,
	input  wire  [DIVISOR_W-1:0]    divisor,
	output nps_pkg::rem_status_t    status
);
	import nps_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIVIDEND_W - 1);

	logic [DIVIDEND_W-1:0] dvd_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  run_q;
	logic                  done_q;

	logic [DIVISOR_W:0] trial;
	logic [DIVISOR_W:0] diff;
	logic [DIVISOR_W-1:0] rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[DIVIDEND_W-1]};
		diff = trial - {1'b0, dvs_q};
		// The partial remainder stays below the divisor, so the kept value fits.
		if (trial >= {1'b0, dvs_q}) begin
			rem_next = diff[DIVISOR_W-1:0];
		end else begin
			rem_next = trial[DIVISOR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (launch) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				rem_q <= '0;
			end else if (run_q) begin
				rem_q <= rem_next;
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_CNT) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], 1'b0};
		end
	end

	assign status.done = done_q;
	assign status.zero = (rem_q == '0);
endmodule
`default_nettype wire

// ----- hdl/nps_seq.sv -----
// Search sequencer: candidate, trial divisor and its square, and control.
`default_nettype none
module nps_seq #(
	parameter int VALUE_WIDTH = 32,
	localparam int DIV_W = VALUE_WIDTH / 2 + 2
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire  [VALUE_WIDTH-1:0]   start_value,
	output logic                     busy,
	output nps_pkg::emit_t           emit,
	output logic [VALUE_WIDTH-1:0]   emit_value,
	output logic                     rem_launch,
	output logic [VALUE_WIDTH-1:0]   rem_dividend,
	output logic [DIV_W-1:0]         rem_divisor,
	input  nps_pkg::rem_status_t     rem_status
);
	import nps_pkg::*;

	localparam int SQ_W = VALUE_WIDTH + 1;

	state_t state_q, state_d;
	logic [VALUE_WIDTH-1:0] cand_q;
	logic [DIV_W-1:0]       div_q;
	logic [SQ_W-1:0]        sq_q;

	logic accept;
	logic small_start;
	logic at_max;
	logic sq_above;
	logic composite;

	assign accept = start && (state_q == ST_IDLE);
	assign small_start = (start_value <= VALUE_WIDTH'(FIRST_PRIME));
	assign at_max = (cand_q == '1);
	assign sq_above = (sq_q > {1'b0, cand_q});
	assign composite = rem_status.done && rem_status.zero;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && !small_start) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (sq_above) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (rem_status.done) begin
					state_d = (composite && at_max) ? ST_IDLE : ST_TEST;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		rem_launch = 1'b0;
		emit = '0;
		emit_value = '0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && small_start) begin
					emit.valid = 1'b1;
					emit_value = VALUE_WIDTH'(FIRST_PRIME);
				end
			end
			ST_TEST: begin
				// No divisor up to the square root divides the candidate.
				if (sq_above) begin
					emit.valid = 1'b1;
					emit_value = cand_q;
				end else begin
					rem_launch = 1'b1;
				end
			end
			ST_WAIT: begin
				if (composite && at_max) begin
					emit.valid = 1'b1;
					emit.overflow = 1'b1;
				end
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cand_q <= '0;
			div_q <= '0;
			sq_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cand_q <= start_value | VALUE_WIDTH'(1);
				div_q <= DIV_W'(FIRST_DIVISOR);
				sq_q <= SQ_W'(FIRST_SQUARE);
			end else if (state_q == ST_WAIT && rem_status.done) begin
				if (rem_status.zero) begin
					// Composite: move to the next odd candidate and restart at three.
					cand_q <= cand_q + VALUE_WIDTH'(ODD_STEP);
					div_q <= DIV_W'(FIRST_DIVISOR);
					sq_q <= SQ_W'(FIRST_SQUARE);
				end else begin
					// (d + 2)^2 = d^2 + 4d + 4
					div_q <= div_q + DIV_W'(ODD_STEP);
					sq_q <= sq_q + SQ_W'({div_q, 2'b00}) + SQ_W'(4);
				end
			end
		end
	end

	assign rem_dividend = cand_q;
	assign rem_divisor = div_q;
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the next prime search block: directed and random start values.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import nps_pkg::*;

	localparam int W = 32;
	localparam int GAP_MAX = 40;
	localparam int TAIL_CYCLES = 4 * (W + 2) + 20;
	localparam logic [W-1:0] TOP = {W{1'b1}};

	typedef struct {
		logic [W-1:0] value;
		bit           drain;
	} search_req_t;

	typedef struct {
		logic [W-1:0] prime;
		logic         ovf;
	} prime_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	logic [W-1:0] start_value = '0;
	wire          busy;
	wire          done;
	wire  [W-1:0] prime_value;
	wire          overflow;

	search_req_t   pending_starts[$];
	prime_result_t expected_primes[$];
	int            error_count = 0;
	longint        cycle_count = 0;
	longint        cycle_limit = 0;
	longint        work_budget = 0;
	int            burst_left = 0;
	int            gap_left = 0;

	next_prime_search #(.VALUE_WIDTH(W)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.start_value (start_value),
		.done        (done),
		.prime_value (prime_value),
		.overflow    (overflow)
	);

	always #10 clk = ~clk;

	always @(posedge clk) cycle_count++;

	// Smallest prime at or above s by odd trial division; also counts the work spent.
	function automatic void search_prime(input logic [W-1:0] s, output logic [W-1:0] p,
			output logic ovf, output longint trials, output longint cands);
		logic [W:0] c;
		logic [W:0] d;
		bit         found;
		bit         composite;
		trials = 0;
		cands = 0;
		p = '0;
		ovf = 1'b0;
		if (s <= W'(FIRST_PRIME)) begin
			p = W'(FIRST_PRIME);
		end else begin
			c = {1'b0, s} | (W + 1)'(1);
			found = 1'b0;
			while (!found) begin
				cands++;
				composite = 1'b0;
				d = (W + 1)'(FIRST_DIVISOR);
				while (!composite && d <= c / d) begin
					trials++;
					if (c % d == '0)
						composite = 1'b1;
					else
						d = d + (W + 1)'(ODD_STEP);
				end
				if (!composite) begin
					p = c[W-1:0];
					found = 1'b1;
				end else if (c > {1'b0, TOP} - (W + 1)'(ODD_STEP)) begin
					ovf = 1'b1;
					found = 1'b1;
				end else begin
					c = c + (W + 1)'(ODD_STEP);
				end
			end
		end
	endfunction

	task automatic add_start(input logic [W-1:0] v, input bit drain);
		search_req_t   req;
		logic [W-1:0]  p;
		logic          o;
		longint        t;
		longint        c;
		req.value = v;
		req.drain = drain;
		pending_starts.push_back(req);
		search_prime(v, p, o, t, c);
		work_budget += t * (W + 2) + 4 * c + GAP_MAX + 20;
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		prime_result_t res;
		longint        n_trials;
		longint        n_cands;
		bit            taken;
		bit            hold;
		bit            offer;
		if (!arst_n) begin
			start <= 1'b0;
			start_value <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				search_prime(start_value, res.prime, res.ovf, n_trials, n_cands);
				expected_primes.push_back(res);
				void'(pending_starts.pop_front());
			end
			hold = start && !taken;
			if (hold)
				offer = 1'b1;
			else if (gap_left > 0) begin
				gap_left--;
				offer = 1'b0;
			end else if (pending_starts.size() == 0)
				offer = 1'b0;
			else if (pending_starts[0].drain && expected_primes.size() != 0)
				offer = 1'b0;
			else
				offer = 1'b1;
			start <= offer;
			if (offer && !hold) begin
				start_value <= pending_starts[0].value;
				if (burst_left == 0)
					burst_left = $urandom_range(1, 6);
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, GAP_MAX);
			end else if (!offer) begin
				start_value <= $urandom();
			end
		end
	end

	always @(posedge clk) begin : monitor
		prime_result_t want;
		if (arst_n && done) begin
			if (expected_primes.size() == 0) begin
				$error("unexpected result: prime_value %0d overflow %0b", prime_value, overflow);
				error_count++;
			end else begin
				want = expected_primes.pop_front();
				if (prime_value !== want.prime) begin
					$error("prime_value: expected %0d, actual %0d", want.prime, prime_value);
					error_count++;
				end
				if (overflow !== want.ovf) begin
					$error("overflow: expected %0b, actual %0b", want.ovf, overflow);
					error_count++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [W-1:0] v;
		int           bucket;
		// Edge starts, squares of small primes, and the overflow region at the top.
		add_start(0, 1'b0);
		add_start(1, 1'b0);
		add_start(2, 1'b0);
		add_start(3, 1'b0);
		add_start(4, 1'b0);
		add_start(8, 1'b0);
		add_start(9, 1'b0);
		add_start(24, 1'b0);
		add_start(25, 1'b0);
		add_start(48, 1'b0);
		add_start(49, 1'b0);
		add_start(120, 1'b0);
		add_start(121, 1'b0);
		add_start(65521, 1'b0);
		add_start(65536, 1'b0);
		add_start(1000000, 1'b0);
		add_start(TOP, 1'b0);
		add_start(TOP - 1, 1'b0);
		add_start(TOP - 3, 1'b0);
		add_start(TOP, 1'b0);
		for (int i = 0; i < 80; i++) begin
			bucket = $urandom_range(0, 99);
			if (bucket < 55)
				v = $urandom_range(0, 4095);
			else if (bucket < 82)
				v = $urandom_range(0, 65535);
			else if (bucket < 90)
				v = $urandom_range(0, (1 << 20) - 1);
			else if (bucket < 95)
				v = $urandom_range(0, FIRST_DIVISOR);
			else
				v = TOP - $urandom_range(0, 1);
			add_start(v, i == 0 || i == 50);
		end
		cycle_limit = 4 * work_budget + 10000;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while ((pending_starts.size() != 0 || expected_primes.size() != 0)
				&& cycle_count < cycle_limit)
			@(posedge clk);
		if (cycle_count >= cycle_limit) begin
			$error("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			if (expected_primes.size() != 0) begin
				$error("%0d expected results never arrived", expected_primes.size());
				error_count++;
			end
			if (error_count == 0)
				$display("Testbench completed without errors");
			else
				$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
`default_nettype wire
